FILE: design/dateinc_pkg.sv
package dateinc_pkg;

    localparam int unsigned DAY_W     = 5;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned WDAY_W    = 3;
    localparam int unsigned CENT_W    = 7;
    localparam int unsigned ZSUM_W    = 10;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;

    // floor(y / 100) for y below 43699 as (y * 5243) >> 19.
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    // floor(s / 7) for s below 1024 as (s * 9363) >> 16.
    localparam logic [13:0] DIV7_MUL   = 14'd9363;

    function automatic logic [CENT_W-1:0] div100(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        prod = 27'(y) * 27'(DIV100_MUL);
        return prod[25:19];
    endfunction

    // Remainder of y modulo 100, given its quotient.
    function automatic logic [CENT_W-1:0] rem100(input logic [YEAR_W-1:0] y,
                                                 input logic [CENT_W-1:0] q);
        logic [YEAR_W-1:0] hund;
        hund = 14'(q) * 14'(100);
        return CENT_W'(y - hund);
    endfunction

    function automatic logic [WDAY_W-1:0] mod7(input logic [ZSUM_W-1:0] s);
        logic [23:0] prod;
        logic [6:0]  q;
        logic [ZSUM_W-1:0] sevens;
        prod   = 24'(s) * 24'(DIV7_MUL);
        q      = prod[22:16];
        sevens = 10'(q) * 10'(7);
        return WDAY_W'(s - sevens);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(13 * (m + 1) / 5) for the Zeller month numbering 3..14.
    function automatic logic [5:0] zeller_month_term(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        unique case (m)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

FILE: design/dateinc_if.sv
interface dateinc_in_if
    import dateinc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;

    modport source (output valid, output day, output month, output year, input ready);
    modport sink   (input valid, input day, input month, input year, output ready);
endinterface

interface dateinc_out_if
    import dateinc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   next_day;
    logic [MONTH_W-1:0] next_month;
    logic [YEAR_W-1:0]  next_year;
    logic [WDAY_W-1:0]  weekday;

    modport source (output valid, output next_day, output next_month, output next_year,
                    output weekday, input ready);
    modport sink   (input valid, input next_day, input next_month, input next_year,
                    input weekday, output ready);
endinterface

FILE: design/date_increment_with_weekday.sv
// Gives the date after the input Gregorian date and the weekday of that date
// (0 is Sunday). Months outside 1..12 and years outside 1..9999 are clamped to
// the nearest legal value first, and 31 December 9999 is followed by 1 January
// of year 1. The block is a five-stage pipeline: it takes one item per cycle
// while the output is not held off, and each item passes through the stages in
// order. The two constant divisions by 100, each a multiply by a reciprocal,
// set the stage boundaries.
module date_increment_with_weekday
    import dateinc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dateinc_in_if.sink    din,
    dateinc_out_if.source dout
);

    localparam int unsigned NSTAGE = 5;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    logic [DAY_W-1:0]   s0_day_reg,   s1_day_reg,   s2_day_reg,   s3_day_reg,   s4_day_reg;
    logic [MONTH_W-1:0] s0_month_reg, s1_month_reg, s2_month_reg, s3_month_reg, s4_month_reg;
    logic [YEAR_W-1:0]  s0_year_reg,  s1_year_reg,  s2_year_reg,  s3_year_reg,  s4_year_reg;
    logic [CENT_W-1:0]  s0_cent_reg;

    logic [MONTH_W-1:0] clamp_month;
    logic [YEAR_W-1:0]  clamp_year;
    logic [CENT_W-1:0]  yr_in_cent;
    logic               leap;
    logic [DAY_W:0]     day_inc;
    logic [DAY_W-1:0]   day_next;
    logic [MONTH_W-1:0] month_next;
    logic [YEAR_W-1:0]  year_next;
    logic [WDAY_W-1:0]  wday;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || dout.ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign din.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= din.valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        priority if (din.month < MONTH_JAN)
            clamp_month = MONTH_JAN;
        else if (din.month > MONTH_DEC)
            clamp_month = MONTH_DEC;
        else
            clamp_month = din.month;

        priority if (din.year < YEAR_MIN)
            clamp_year = YEAR_MIN;
        else if (din.year > YEAR_MAX)
            clamp_year = YEAR_MAX;
        else
            clamp_year = din.year;
    end

    // A year divisible by 400 is one whose last two digits are zero and whose
    // century count is a multiple of four.
    always_comb
    begin
        yr_in_cent = rem100(s0_year_reg, s0_cent_reg);
        leap = (s0_year_reg[1:0] == 2'd0 && yr_in_cent != '0)
            || (yr_in_cent == '0 && s0_cent_reg[1:0] == 2'd0);
        day_inc = (DAY_W+1)'(s0_day_reg) + 6'd1;

        day_next   = DAY_W'(day_inc);
        month_next = s0_month_reg;
        year_next  = s0_year_reg;
        if (day_inc > (DAY_W+1)'(month_len(s0_month_reg, leap)))
        begin
            day_next = 5'd1;
            if (s0_month_reg == MONTH_DEC)
            begin
                month_next = MONTH_JAN;
                year_next  = (s0_year_reg >= YEAR_MAX) ? YEAR_MIN
                                                       : YEAR_W'(s0_year_reg + 14'd1);
            end
            else
            begin
                month_next = MONTH_W'(s0_month_reg + 4'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_day_reg   <= din.day;
            s0_month_reg <= clamp_month;
            s0_year_reg  <= clamp_year;
            s0_cent_reg  <= div100(clamp_year);
        end
        if (en[1])
        begin
            s1_day_reg   <= day_next;
            s1_month_reg <= month_next;
            s1_year_reg  <= year_next;
        end
        if (en[2])
        begin
            s2_day_reg   <= s1_day_reg;
            s2_month_reg <= s1_month_reg;
            s2_year_reg  <= s1_year_reg;
        end
        if (en[3])
        begin
            s3_day_reg   <= s2_day_reg;
            s3_month_reg <= s2_month_reg;
            s3_year_reg  <= s2_year_reg;
        end
        if (en[4])
        begin
            s4_day_reg   <= s3_day_reg;
            s4_month_reg <= s3_month_reg;
            s4_year_reg  <= s3_year_reg;
        end
    end

    dateinc_weekday u_weekday (
        .clk     (clk),
        .load    (en[4:2]),
        .day     (s1_day_reg),
        .month   (s1_month_reg),
        .year    (s1_year_reg),
        .weekday (wday)
    );

    assign dout.valid      = valid_reg[NSTAGE-1];
    assign dout.next_day   = s4_day_reg;
    assign dout.next_month = s4_month_reg;
    assign dout.next_year  = s4_year_reg;
    assign dout.weekday    = wday;

endmodule

FILE: design/dateinc_weekday.sv
module dateinc_weekday
    import dateinc_pkg::*;
(
    input  logic               clk,
    input  logic [2:0]         load,
    input  logic [DAY_W-1:0]   day,
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    output logic [WDAY_W-1:0]  weekday
);

    logic [DAY_W-1:0]   a_day_reg;
    logic [MONTH_W-1:0] a_month_reg;
    logic [YEAR_W-1:0]  a_year_reg;
    logic [CENT_W-1:0]  a_cent_reg;
    logic [ZSUM_W-1:0]  b_sum_reg;
    logic [WDAY_W-1:0]  c_wday_reg;

    logic [MONTH_W-1:0] adj_month;
    logic [YEAR_W-1:0]  adj_year;
    logic [CENT_W-1:0]  yr_in_cent;
    logic [ZSUM_W-1:0]  sum_next;

    // January and February count as months 13 and 14 of the year before.
    always_comb
    begin
        if (month <= MONTH_FEB)
        begin
            adj_month = MONTH_W'(month + 4'd12);
            adj_year  = YEAR_W'(year - 14'd1);
        end
        else
        begin
            adj_month = month;
            adj_year  = year;
        end
    end

    always_comb
    begin
        yr_in_cent = rem100(a_year_reg, a_cent_reg);
        sum_next   = ZSUM_W'(a_day_reg) + ZSUM_W'(zeller_month_term(a_month_reg))
                   + ZSUM_W'(yr_in_cent) + ZSUM_W'(yr_in_cent >> 2)
                   + ZSUM_W'(a_cent_reg >> 2) + ZSUM_W'(a_cent_reg) * ZSUM_W'(5);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            a_day_reg   <= day;
            a_month_reg <= adj_month;
            a_year_reg  <= adj_year;
            a_cent_reg  <= div100(adj_year);
        end
        if (load[1])
        begin
            b_sum_reg <= sum_next;
        end
        // Zeller's zero is Saturday; adding six moves zero to Sunday.
        if (load[2])
        begin
            c_wday_reg <= mod7(ZSUM_W'(b_sum_reg + 10'd6));
        end
    end

    assign weekday = c_wday_reg;

endmodule

FILE: design/dateinc_chk.sv
module dateinc_chk
    import dateinc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [DAY_W-1:0]   next_day,
    input logic [MONTH_W-1:0] next_month,
    input logic [YEAR_W-1:0]  next_year,
    input logic [WDAY_W-1:0]  weekday
);

    // The input side is held off only when every stage is full and the output stalls.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input held off while the output is free");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(next_day)
            && $stable(next_month) && $stable(next_year) && $stable(weekday)))
        else $error("stalled result changed or dropped");

    a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (next_day != '0 && next_month != '0 && next_month <= MONTH_DEC
            && next_year != '0 && next_year <= YEAR_MAX && weekday <= 3'd6))
        else $error("result field out of range");

    a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && next_month == MONTH_FEB) |-> (next_day <= 5'd29))
        else $error("February day past its length");

endmodule

bind date_increment_with_weekday dateinc_chk u_dateinc_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (din.ready),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .next_day   (dout.next_day),
    .next_month (dout.next_month),
    .next_year  (dout.next_year),
    .weekday    (dout.weekday)
);
